// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the hex-float text converter.
// Depends on nothing; SYNTH builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: invariant failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/fthf_pkg.sv -----
// Package for the fixed-point to hex-float text converter: control word
// types, the sequencer program and ASCII helpers. Depends on nothing.
`default_nettype none

package fthf_pkg;

	localparam int UPC_W = 4;
	localparam int NSTEPS = 1 << UPC_W;

	typedef logic [UPC_W-1:0] upc_t;

	typedef enum logic [3:0] {
		CH_NONE,
		CH_MINUS_IF_NEG,
		CH_ZERO,
		CH_X,
		CH_LEAD,
		CH_DOT_IF_KEEP,
		CH_FRAC_IF_MORE,
		CH_P,
		CH_ESIGN,
		CH_TENS_IF,
		CH_ONES
	} chr_sel_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_SHR,
		OP_SHL,
		OP_ADJ,
		OP_TRIM,
		OP_FRAC
	} dp_op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_SHR,
		C_SHL,
		C_FRAC_MORE
	} cond_t;

	typedef struct packed {
		chr_sel_t chr;
		dp_op_t   op;
		cond_t    cond;
		upc_t     target;
	} ucode_t;

	localparam upc_t STEP_LOAD = upc_t'(0);
	localparam upc_t STEP_SHR  = upc_t'(2);
	localparam upc_t STEP_SHL  = upc_t'(3);
	localparam upc_t STEP_FRAC = upc_t'(9);

	localparam logic [6:0] CHR_0     = 7'h30;
	localparam logic [6:0] CHR_A_LOW = 7'h57;
	localparam logic [6:0] CHR_MINUS = 7'h2d;
	localparam logic [6:0] CHR_PLUS  = 7'h2b;
	localparam logic [6:0] CHR_DOT   = 7'h2e;
	localparam logic [6:0] CHR_X     = 7'h78;
	localparam logic [6:0] CHR_P     = 7'h70;

	// Sequencer program; a step jumps to target when its condition holds,
	// else advances. Spare entries return to the load step.
	localparam ucode_t UCODE [NSTEPS] = '{
		'{CH_NONE,         OP_LOAD, C_NO_INPUT,  STEP_LOAD},
		'{CH_MINUS_IF_NEG, OP_NONE, C_NEVER,     STEP_LOAD},
		'{CH_NONE,         OP_SHR,  C_SHR,       STEP_SHR},
		'{CH_NONE,         OP_SHL,  C_SHL,       STEP_SHL},
		'{CH_NONE,         OP_ADJ,  C_NEVER,     STEP_LOAD},
		'{CH_ZERO,         OP_TRIM, C_NEVER,     STEP_LOAD},
		'{CH_X,            OP_NONE, C_NEVER,     STEP_LOAD},
		'{CH_LEAD,         OP_NONE, C_NEVER,     STEP_LOAD},
		'{CH_DOT_IF_KEEP,  OP_NONE, C_NEVER,     STEP_LOAD},
		'{CH_FRAC_IF_MORE, OP_FRAC, C_FRAC_MORE, STEP_FRAC},
		'{CH_P,            OP_NONE, C_NEVER,     STEP_LOAD},
		'{CH_ESIGN,        OP_NONE, C_NEVER,     STEP_LOAD},
		'{CH_TENS_IF,      OP_NONE, C_NEVER,     STEP_LOAD},
		'{CH_ONES,         OP_NONE, C_ALWAYS,    STEP_LOAD},
		'{CH_NONE,         OP_NONE, C_ALWAYS,    STEP_LOAD},
		'{CH_NONE,         OP_NONE, C_ALWAYS,    STEP_LOAD}
	};

	function automatic logic [6:0] hex_char(input logic [3:0] d);
		if (d < 4'd10)
			return CHR_0 + {3'b000, d};
		return CHR_A_LOW + {3'b000, d};
	endfunction

	// Count of fraction digits up to and including the last nonzero one.
	function automatic logic [3:0] frac_keep(input logic [31:0] f);
		logic [3:0] k;
		k = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (f[31-4*i -: 4] != 4'd0)
				k = 4'(i + 1);
		end
		return k;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fixed_to_hex_float_text.sv -----
// Top level of the fixed-point to hex-float text converter: a microcoded
// sequencer over a shift/count datapath. Depends on fthf_pkg and assert_macros.svh.
//
// Usage:
//  - Input channel value_valid/value_ready carries one signed 32.32 value.
//    value_ready is high only while the sequencer sits in its load step.
//  - Output channel character_valid/character_ready carries one ASCII
//    character per transfer; last marks the final character of a value.
//  - Text form: [-]0xD.FFFFFFFFp<sign>E, trailing zero digits trimmed,
//    exponent in decimal; zero gives 0x0p+0.
//  - Each value runs through 14 sequencer steps; the shift steps repeat once per
//    normalizing shift (0 to 32) and the fraction step once per fraction digit
//    kept (0 to 8). Normalization shifts one bit per cycle.
//  - Characters leave through one output register; a step that emits waits
//    while that register holds an untaken character, so a stalled receiver
//    stalls the sequencer and nothing is lost or repeated.
//  - For a negative value the first character is the minus sign from the step
//    after the load step; otherwise it is the 0 emitted after normalization.
//  - Reset (arst_n low) returns the sequencer to the load step and empties
//    the output register.
`default_nettype none
`include "assert_macros.svh"

module fixed_to_hex_float_text (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic signed [63:0] value,
	input  wire logic               value_valid,
	output logic                    value_ready,
	output logic [6:0]              character,
	output logic                    last,
	output logic                    character_valid,
	input  wire logic               character_ready
);
	import fthf_pkg::*;

	upc_t              upc_q;
	upc_t              upc_d;
	ucode_t            uw;
	logic [63:0]       mag_q;
	logic signed [6:0] exp_q;
	logic              neg_q;
	logic [3:0]        keep_q;
	logic [3:0]        cnt_q;

	logic              emit_want;
	logic              slot_free;
	logic              fire;
	logic              cond_true;
	logic [6:0]        chr_d;
	logic [5:0]        ae;
	logic [1:0]        tens;
	logic [5:0]        ones;

	assign uw          = UCODE[upc_q];
	assign value_ready = (upc_q == STEP_LOAD);
	assign slot_free   = !character_valid || character_ready;
	assign fire        = !emit_want || slot_free;

	always_comb begin
		ae = exp_q[6] ? 6'(-exp_q) : exp_q[5:0];
		if (ae >= 6'd30)
			tens = 2'd3;
		else if (ae >= 6'd20)
			tens = 2'd2;
		else if (ae >= 6'd10)
			tens = 2'd1;
		else
			tens = 2'd0;
		ones = ae - {1'b0, tens, 3'b000} - {3'b000, tens, 1'b0};
	end

	always_comb begin
		case (uw.cond)
			C_NEVER:     cond_true = 1'b0;
			C_ALWAYS:    cond_true = 1'b1;
			C_NO_INPUT:  cond_true = !value_valid;
			C_SHR:       cond_true = (mag_q[63:32] != 32'd0);
			C_SHL:       cond_true = (mag_q != 64'd0) && !mag_q[31];
			C_FRAC_MORE: cond_true = (cnt_q < keep_q);
			default:     cond_true = 1'b1;
		endcase
	end

	always_comb begin
		emit_want = 1'b1;
		chr_d     = CHR_0;
		case (uw.chr)
			CH_NONE: begin
				emit_want = 1'b0;
			end
			CH_MINUS_IF_NEG: begin
				emit_want = neg_q;
				chr_d     = CHR_MINUS;
			end
			CH_ZERO: begin
				chr_d = CHR_0;
			end
			CH_X: begin
				chr_d = CHR_X;
			end
			CH_LEAD: begin
				chr_d = hex_char(mag_q[35:32]);
			end
			CH_DOT_IF_KEEP: begin
				emit_want = (keep_q != 4'd0);
				chr_d     = CHR_DOT;
			end
			CH_FRAC_IF_MORE: begin
				emit_want = (cnt_q < keep_q);
				chr_d     = hex_char(mag_q[31:28]);
			end
			CH_P: begin
				chr_d = CHR_P;
			end
			CH_ESIGN: begin
				chr_d = exp_q[6] ? CHR_MINUS : CHR_PLUS;
			end
			CH_TENS_IF: begin
				emit_want = (ae >= 6'd10);
				chr_d     = CHR_0 + {5'd0, tens};
			end
			CH_ONES: begin
				chr_d = CHR_0 + {1'b0, ones};
			end
			default: begin
				emit_want = 1'b0;
			end
		endcase
	end

	always_comb begin
		upc_d = upc_q;
		if (fire) begin
			if (cond_true)
				upc_d = uw.target;
			else
				upc_d = upc_q + upc_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_LOAD;
		end else begin
			upc_q <= upc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q  <= '0;
			exp_q  <= '0;
			neg_q  <= 1'b0;
			keep_q <= '0;
			cnt_q  <= '0;
		end else if (fire) begin
			case (uw.op)
				OP_LOAD: begin
					if (value_valid) begin
						neg_q <= value[63];
						mag_q <= value[63] ? (64'd0 - 64'(value)) : 64'(value);
						exp_q <= '0;
						cnt_q <= '0;
					end
				end
				OP_SHR: begin
					if (cond_true) begin
						mag_q <= mag_q >> 1;
						exp_q <= exp_q + 7'sd1;
					end
				end
				OP_SHL: begin
					if (cond_true) begin
						mag_q <= mag_q << 1;
						exp_q <= exp_q - 7'sd1;
					end
				end
				OP_ADJ: begin
					if (exp_q != 7'sd0) begin
						mag_q <= mag_q << 1;
						exp_q <= exp_q - 7'sd1;
					end
				end
				OP_TRIM: begin
					keep_q <= frac_keep(mag_q[31:0]);
				end
				OP_FRAC: begin
					if (cond_true) begin
						mag_q <= mag_q << 4;
						cnt_q <= cnt_q + 4'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Hold the character until its transfer; load a new one when the slot frees.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			character_valid <= 1'b0;
			character       <= '0;
			last            <= 1'b0;
		end else if (emit_want && slot_free) begin
			character_valid <= 1'b1;
			character       <= chr_d;
			last            <= (uw.chr == CH_ONES);
		end else if (character_ready) begin
			character_valid <= 1'b0;
		end
	end

	`ASSERT_ALWAYS(a_exp_range, clk, arst_n, (exp_q >= -7'sd32) && (exp_q <= 7'sd32))
	`ASSERT_ALWAYS(a_cnt_le_keep, clk, arst_n, (upc_q != STEP_FRAC) || (cnt_q <= keep_q))
	`ASSERT_ALWAYS(a_norm_done, clk, arst_n, (upc_q < 4'd5) || (upc_q > 4'd8) || (mag_q[63:33] == 31'd0))
	`ASSERT_NEXT(a_load_advance, clk, arst_n, value_valid && value_ready, upc_q == upc_t'(1))

endmodule

`default_nettype wire
